### src/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies; the including module must provide i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// implication checked on every clock edge outside reset
`define QVR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("assertion failed");
// plain check, also active while reset is applied
`define QVR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
    else $error("assertion failed");
`else
`define QVR_ASSERT(lbl, prop)
`define QVR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### src/qvr_pkg.sv
// shared types and constants of the quaternion rotation block
// no dependencies
package qvr_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * WORD_W;
    // four products of magnitude up to 2^62 need two guard bits
    localparam int SUM_W         = PROD_W + 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        t_word w;
    } t_quat;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

### src/qvr_if.sv
// valid/ready channel interfaces for the input item and the result item
// depends on qvr_pkg
interface qvr_in_if;
    import qvr_pkg::*;

    logic  valid;
    logic  ready;
    t_word rot_x;
    t_word rot_y;
    t_word rot_z;
    t_word rot_w;
    t_word vec_x;
    t_word vec_y;
    t_word vec_z;
    t_word vec_w;

    modport source (
        output valid, rot_x, rot_y, rot_z, rot_w, vec_x, vec_y, vec_z, vec_w,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, rot_w, vec_x, vec_y, vec_z, vec_w,
        output ready
    );
endinterface

interface qvr_out_if;
    import qvr_pkg::*;

    logic  valid;
    logic  ready;
    t_word out_x;
    t_word out_y;
    t_word out_z;
    t_word out_w;

    modport source (
        output valid, out_x, out_y, out_z, out_w,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w,
        output ready
    );
endinterface

### src/quaternion_vector_rotate.sv
// Rotates a quaternion by rot * vec * conj(rot) in signed fixed point with
// FRAC_BITS fraction bits. Six register stages: products of the first
// Hamilton product, their sums, round-down and saturation to the middle
// quaternion, then products, sums and saturation of the second product.
// One item is taken every cycle unless every stage is full and the output is
// stalled. Each stage advances on its own when its successor has room, so
// bubbles close up while a result waits at the output.
`include "assert_macros.svh"

module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qvr_in_if.sink    i_item,
    qvr_out_if.source o_res
);

    localparam int NSTG = 6;

    // arithmetic shift by FRAC_BITS, then clamp to the word range
    function automatic t_word sat_word(input t_sum s);
        t_sum                  sh;
        logic [SUM_W-WORD_W:0] top;
        sh  = s >>> FRAC_BITS;
        top = sh[SUM_W-1:WORD_W-1];
        if (&top || ~|top) begin
            return sh[WORD_W-1:0];
        end else if (top[SUM_W-WORD_W]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    function automatic t_prod mul(input t_word a, input t_word b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic t_sum ext(input t_prod p);
        return SUM_W'(p);
    endfunction

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] rdy;
    t_quat           in_rot;
    t_quat           in_vec;

    // stage registers
    t_prod r_p1 [16];
    t_quat r_rot1;
    t_sum  r_s2 [4];
    t_quat r_rot2;
    t_quat r_mid3;
    t_quat r_rot3;
    t_prod r_p4 [16];
    t_sum  r_s5 [4];
    t_quat r_res6;

    t_prod n_p1 [16];
    t_prod n_p4 [16];

    assign in_rot = '{x: i_item.rot_x, y: i_item.rot_y, z: i_item.rot_z, w: i_item.rot_w};
    assign in_vec = '{x: i_item.vec_x, y: i_item.vec_y, z: i_item.vec_z, w: i_item.vec_w};

    // per-stage room: a stage loads when empty or when its successor loads
    always_comb begin
        rdy[NSTG-1] = !r_v[NSTG-1] || o_res.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign i_item.ready = rdy[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_item.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // products of rot * vec, four per component
    always_comb begin
        n_p1[0]  = mul(in_rot.w, in_vec.x);
        n_p1[1]  = mul(in_rot.x, in_vec.w);
        n_p1[2]  = mul(in_rot.y, in_vec.z);
        n_p1[3]  = mul(in_rot.z, in_vec.y);
        n_p1[4]  = mul(in_rot.w, in_vec.y);
        n_p1[5]  = mul(in_rot.x, in_vec.z);
        n_p1[6]  = mul(in_rot.y, in_vec.w);
        n_p1[7]  = mul(in_rot.z, in_vec.x);
        n_p1[8]  = mul(in_rot.w, in_vec.z);
        n_p1[9]  = mul(in_rot.x, in_vec.y);
        n_p1[10] = mul(in_rot.y, in_vec.x);
        n_p1[11] = mul(in_rot.z, in_vec.w);
        n_p1[12] = mul(in_rot.w, in_vec.w);
        n_p1[13] = mul(in_rot.x, in_vec.x);
        n_p1[14] = mul(in_rot.y, in_vec.y);
        n_p1[15] = mul(in_rot.z, in_vec.z);
    end

    // products of mid * conj(rot); conjugate signs folded into the sums
    always_comb begin
        n_p4[0]  = mul(r_mid3.w, r_rot3.x);
        n_p4[1]  = mul(r_mid3.x, r_rot3.w);
        n_p4[2]  = mul(r_mid3.y, r_rot3.z);
        n_p4[3]  = mul(r_mid3.z, r_rot3.y);
        n_p4[4]  = mul(r_mid3.w, r_rot3.y);
        n_p4[5]  = mul(r_mid3.x, r_rot3.z);
        n_p4[6]  = mul(r_mid3.y, r_rot3.w);
        n_p4[7]  = mul(r_mid3.z, r_rot3.x);
        n_p4[8]  = mul(r_mid3.w, r_rot3.z);
        n_p4[9]  = mul(r_mid3.x, r_rot3.y);
        n_p4[10] = mul(r_mid3.y, r_rot3.x);
        n_p4[11] = mul(r_mid3.z, r_rot3.w);
        n_p4[12] = mul(r_mid3.w, r_rot3.w);
        n_p4[13] = mul(r_mid3.x, r_rot3.x);
        n_p4[14] = mul(r_mid3.y, r_rot3.y);
        n_p4[15] = mul(r_mid3.z, r_rot3.z);
    end

    // payload registers, loaded on each stage's transfer
    always_ff @(posedge i_clk) begin
        // stage 1: first products
        if (rdy[0] && i_item.valid) begin
            r_p1   <= n_p1;
            r_rot1 <= in_rot;
        end
        // stage 2: exact sums of rot * vec
        if (rdy[1] && r_v[0]) begin
            r_s2[0] <= ext(r_p1[0]) + ext(r_p1[1]) + ext(r_p1[2]) - ext(r_p1[3]);
            r_s2[1] <= ext(r_p1[4]) - ext(r_p1[5]) + ext(r_p1[6]) + ext(r_p1[7]);
            r_s2[2] <= ext(r_p1[8]) + ext(r_p1[9]) - ext(r_p1[10]) + ext(r_p1[11]);
            r_s2[3] <= ext(r_p1[12]) - ext(r_p1[13]) - ext(r_p1[14]) - ext(r_p1[15]);
            r_rot2  <= r_rot1;
        end
        // stage 3: middle quaternion rounded down and saturated
        if (rdy[2] && r_v[1]) begin
            r_mid3 <= '{x: sat_word(r_s2[0]), y: sat_word(r_s2[1]),
                        z: sat_word(r_s2[2]), w: sat_word(r_s2[3])};
            r_rot3 <= r_rot2;
        end
        // stage 4: second products
        if (rdy[3] && r_v[2]) begin
            r_p4 <= n_p4;
        end
        // stage 5: exact sums of mid * conj(rot)
        if (rdy[4] && r_v[3]) begin
            r_s5[0] <= ext(r_p4[1]) + ext(r_p4[3]) - ext(r_p4[0]) - ext(r_p4[2]);
            r_s5[1] <= ext(r_p4[5]) + ext(r_p4[6]) - ext(r_p4[4]) - ext(r_p4[7]);
            r_s5[2] <= ext(r_p4[10]) + ext(r_p4[11]) - ext(r_p4[8]) - ext(r_p4[9]);
            r_s5[3] <= ext(r_p4[12]) + ext(r_p4[13]) + ext(r_p4[14]) + ext(r_p4[15]);
        end
        // stage 6: output register
        if (rdy[5] && r_v[4]) begin
            r_res6 <= '{x: sat_word(r_s5[0]), y: sat_word(r_s5[1]),
                        z: sat_word(r_s5[2]), w: sat_word(r_s5[3])};
        end
    end

    assign o_res.valid = r_v[NSTG-1];
    assign o_res.out_x = r_res6.x;
    assign o_res.out_y = r_res6.y;
    assign o_res.out_z = r_res6.z;
    assign o_res.out_w = r_res6.w;

    // input is held off only when every stage is occupied
    `QVR_ASSERT(a_stall_only_full, !i_item.ready |-> &r_v)
    // an input transfer always lands in the first stage
    `QVR_ASSERT(a_accept_lands, (i_item.valid && i_item.ready) |=> r_v[0])
    // a blocked middle stage keeps its quaternion
    `QVR_ASSERT(a_mid_hold, (r_v[2] && !rdy[3]) |=> (r_v[2] && $stable(r_mid3)))
    // nothing valid in the pipeline right after reset
    `QVR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (r_v == '0))

endmodule

### bench/tb_quaternion_vector_rotate.sv
// testbench of quaternion_vector_rotate: directed and random rotations, each
// result compared field by field against a fixed-point predictor kept here
// depends on qvr_pkg, qvr_if.sv and quaternion_vector_rotate.sv
module tb_quaternion_vector_rotate
    import qvr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FRAC_BITS_DEF;

    // wide signed accumulator, far more than the four summed products need
    typedef logic signed [127:0] t_acc;
    typedef struct {
        t_acc x;
        t_acc y;
        t_acc z;
        t_acc w;
    } t_wide_quat;

    // one input transfer: rotation quaternion and the quaternion it rotates
    typedef struct packed {
        t_quat rot;
        t_quat vec;
    } t_pair;

    localparam t_acc  ACC_MAX  = 128'sh7fff_ffff;
    localparam t_acc  ACC_MIN  = -ACC_MAX - 128'sd1;
    localparam t_word Q_ONE    = 32'sd1 <<< FRAC;
    localparam t_word Q_2ONE   = 32'sd2 <<< FRAC;
    // cos and sin of 45 degrees, 0.70711 scaled to the fraction width
    localparam t_word Q_COS45  = t_word'((longint'(46341) << FRAC) >> 16);
    localparam t_word ALL_ONES = '1;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    int   n_mismatch;

    t_quat pending_rotations[$];

    qvr_in_if  in_ch ();
    qvr_out_if out_ch ();

    quaternion_vector_rotate #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (in_ch),
        .o_res   (out_ch)
    );

    // clock, 4 ns period
    always begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // arithmetic shift down by the fraction width, then clamp to 32 bits
    function automatic t_acc round_sat(t_acc sum);
        t_acc sh;
        sh = sum >>> FRAC;
        if (sh > ACC_MAX) return ACC_MAX;
        if (sh < ACC_MIN) return ACC_MIN;
        return sh;
    endfunction

    // hamilton product a*b, each component rounded and saturated
    function automatic t_wide_quat hamilton_sat(t_wide_quat a, t_wide_quat b);
        t_wide_quat r;
        r.x = round_sat(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
        r.y = round_sat(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
        r.z = round_sat(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
        r.w = round_sat(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
        return r;
    endfunction

    function automatic t_wide_quat widen(t_quat q);
        t_wide_quat r;
        r.x = signed'(q.x);
        r.y = signed'(q.y);
        r.z = signed'(q.z);
        r.w = signed'(q.w);
        return r;
    endfunction

    // rot * vec * conj(rot); the conjugate is negated exactly in wide form
    function automatic t_quat predict_rotation(t_pair p);
        t_wide_quat rot;
        t_wide_quat conj;
        t_wide_quat mid;
        t_wide_quat res;
        t_quat      rotated;
        rot    = widen(p.rot);
        conj.x = -rot.x;
        conj.y = -rot.y;
        conj.z = -rot.z;
        conj.w = rot.w;
        mid    = hamilton_sat(rot, widen(p.vec));
        res    = hamilton_sat(mid, conj);
        rotated.x = t_word'(res.x);
        rotated.y = t_word'(res.y);
        rotated.z = t_word'(res.z);
        rotated.w = t_word'(res.w);
        return rotated;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_quat make_quat(t_word x, t_word y, t_word z, t_word w);
        t_quat q;
        q.x = x;
        q.y = y;
        q.z = z;
        q.w = w;
        return q;
    endfunction

    // send one item and record its expected result once transferred
    task automatic send_pair(t_quat rot, t_quat vec);
        t_pair p;
        int    gap;
        p.rot = rot;
        p.vec = vec;
        gap   = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rot_x <= rot.x;
        in_ch.rot_y <= rot.y;
        in_ch.rot_z <= rot.z;
        in_ch.rot_w <= rot.w;
        in_ch.vec_x <= vec.x;
        in_ch.vec_y <= vec.y;
        in_ch.vec_z <= vec.z;
        in_ch.vec_w <= vec.w;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        pending_rotations.push_back(predict_rotation(p));
    endtask

    // identity rotation, rounding of all-ones words, non-zero scalar part
    task automatic test_identity();
        t_quat unit;
        unit = make_quat(0, 0, 0, Q_ONE);
        send_pair(unit, make_quat(Q_ONE, Q_2ONE, -3 * Q_ONE, 0));
        send_pair(unit, make_quat(WORD_MAX, WORD_MIN, WORD_MAX, 0));
        send_pair(unit, make_quat(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_pair(unit, make_quat(Q_ONE, 0, -Q_ONE, 5 * Q_ONE));
    endtask

    // quarter turns about each axis, both senses about y and z, and a half turn
    task automatic test_quarter_turns();
        t_quat vec;
        vec = make_quat(Q_ONE, Q_2ONE, 3 * Q_ONE, 0);
        send_pair(make_quat(0, 0, Q_COS45, Q_COS45), vec);
        send_pair(make_quat(Q_COS45, 0, 0, Q_COS45), vec);
        send_pair(make_quat(0, Q_COS45, 0, Q_COS45), vec);
        send_pair(make_quat(0, 0, -Q_COS45, Q_COS45), vec);
        send_pair(make_quat(0, -Q_COS45, 0, Q_COS45), make_quat(-Q_ONE, 7, -9, Q_ONE));
        send_pair(make_quat(Q_ONE, 0, 0, 0), vec);
    endtask

    // field extremes, saturation, exact conjugate of the most negative word,
    // unnormalised scaling and round-down of tiny negative values
    task automatic test_extremes();
        send_pair(make_quat(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN),
                  make_quat(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        send_pair(make_quat(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX),
                  make_quat(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        send_pair(make_quat(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX),
                  make_quat(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
        send_pair(make_quat(WORD_MIN, 0, 0, 0), make_quat(Q_ONE, 0, 0, 0));
        send_pair(make_quat(0, 0, WORD_MIN, 0), make_quat(0, Q_ONE, Q_ONE, Q_ONE));
        send_pair(make_quat(0, 0, 0, 0), make_quat(0, 0, 0, 0));
        send_pair(make_quat(0, 0, 0, Q_2ONE), make_quat(1 << 29, -(1 << 29), 1 << 27, 0));
        send_pair(make_quat(1, -1, 1, -1), make_quat(ALL_ONES, 1, ALL_ONES, 0));
        send_pair(make_quat(Q_COS45, 0, 0, Q_COS45), make_quat(ALL_ONES, ALL_ONES, 1, 0));
    endtask

    function automatic t_word rand_span(int unsigned mag);
        return t_word'($urandom_range(0, 2 * mag) - mag);
    endfunction

    function automatic t_word rand_special();
        case ($urandom_range(0, 6))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return ALL_ONES;
            4: return Q_ONE;
            5: return -Q_ONE;
            default: return 1;
        endcase
    endfunction

    // any of the value classes, chosen per field
    function automatic t_word rand_mixed();
        case ($urandom_range(0, 3))
            0: return rand_span(Q_ONE);
            1: return rand_span(1 << 24);
            2: return t_word'($urandom());
            default: return rand_special();
        endcase
    endfunction

    // random stream: half rotations with fields in +-1 on moderate vectors, the rest
    // full-range words and mixes of boundary values
    task automatic test_random_stream();
        t_quat rot;
        t_quat vec;
        int    kind;
        for (int n = 0; n < 550; n++) begin
            if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 3);
            if (kind < 2) begin
                rot = make_quat(rand_span(Q_ONE), rand_span(Q_ONE), rand_span(Q_ONE),
                                rand_span(Q_ONE));
                vec = make_quat(rand_span(1 << 24), rand_span(1 << 24), rand_span(1 << 24),
                                ($urandom_range(0, 4) == 0) ? rand_span(1 << 24) : '0);
            end else if (kind == 2) begin
                rot = make_quat($urandom(), $urandom(), $urandom(), $urandom());
                vec = make_quat($urandom(), $urandom(), $urandom(), $urandom());
            end else begin
                rot = make_quat(rand_mixed(), rand_mixed(), rand_mixed(), rand_mixed());
                vec = make_quat(rand_mixed(), rand_mixed(), rand_mixed(), rand_mixed());
            end
            send_pair(rot, vec);
        end
    endtask

    task automatic check_field(string name, t_word want, t_word got);
        if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // result side: compare every transfer with the oldest expectation
    always @(posedge clk) begin
        t_quat want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_rotations.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d w=%0d",
                             out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w);
            end else begin
                want = pending_rotations.pop_front();
                check_field("out_x", want.x, out_ch.out_x);
                check_field("out_y", want.y, out_ch.out_y);
                check_field("out_z", want.z, out_ch.out_z);
                check_field("out_w", want.w, out_ch.out_w);
            end
        end
    end

    // result side back-pressure: ready windows broken by random stalls
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            stall = idle_on ? pick_gap() : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("FAIL quaternion_vector_rotate");
        $finish;
    end

    // test sequence
    initial begin
        rst_n       = 1'b0;
        idle_on     = 1'b1;
        n_mismatch  = 0;
        in_ch.valid = 1'b0;
        in_ch.rot_x = '0;
        in_ch.rot_y = '0;
        in_ch.rot_z = '0;
        in_ch.rot_w = '0;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        in_ch.vec_w = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity();
        test_quarter_turns();
        test_extremes();
        test_random_stream();
        in_ch.valid <= 1'b0;

        // drain, then allow for the six-stage pipeline to go quiet
        while (pending_rotations.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_mismatch == 0)
            $display("PASS quaternion_vector_rotate");
        else
            $display("FAIL quaternion_vector_rotate");
        $finish;
    end

endmodule
